// ----- rtl/sensor_sample_conditioner_defines.svh -----
// Assertion macros shared by the sensor sample conditioner checkers.
`ifndef SENSOR_SAMPLE_CONDITIONER_DEFINES_SVH
`define SENSOR_SAMPLE_CONDITIONER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication that also holds across reset.
`define SSC_ASSERT_NEXT_ANY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- rtl/ssc_pkg.sv -----
// Shared types and constants of the sensor sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   localparam int WINDOW_DEPTH_DEF = 3;

   localparam int SAMPLE_W    = 16;
   localparam int TEMP_W      = 16;
   localparam int RAW_W       = 24;
   localparam int PRESS_OUT_W = 19;
   localparam int SUM_W       = 17;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 2;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_TEMP_CODE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_TEMP_LIMIT  = 4'd1;

   localparam logic [TEMP_W-1:0] INVALID_TEMP_RESET = 16'hFFFF;
   localparam logic [TEMP_W-1:0] UPPER_LIMIT_RESET  = 16'd8000;

   localparam logic [RAW_W-1:0] RAW_ZERO     = 24'h000000;
   localparam logic [RAW_W-1:0] RAW_POS_FULL = 24'h7FFFFF;
   localparam logic [RAW_W-1:0] RAW_NEG_FULL = 24'hFFFFFF;

   // The pressure scale is floor((sum * 375031 + 50000) / 100000), where sum is
   // twice the median or the sum of the two middle samples. The division is a
   // shift by five followed by a reciprocal multiply for 3125 with one correction.
   localparam int SCALED_W    = 36;
   localparam int QUOT_IN_W   = 31;
   localparam int PROD_W      = 63;
   localparam int QUOT_W      = 20;
   localparam int DIV_SHIFT   = 5;
   localparam int RECIP_SHIFT = 43;
   localparam int REM_W       = 32;

   localparam logic [18:0]          SCALE_MUL = 19'd375031;
   localparam logic [SCALED_W-1:0]  ROUND_ADD = 36'd50000;
   localparam logic [31:0]          RECIP_M   = 32'd2814749767;
   localparam logic [11:0]          DIV_REM   = 12'd3125;

   typedef struct packed {
      logic accept;
      logic en1;
      logic en2;
      logic en3;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_left;
      logic [TEMP_W-1:0] temp_right;
      logic              rejected;
      logic              channel;
   } rtd_result_type;

endpackage

`default_nettype wire

// ----- rtl/sensor_sample_conditioner.sv -----
// Top level of the sensor sample conditioner.
//
//   Channel | Direction | Handshake         | Payload
//   req     | in        | tvalid / tready   | tdata: raw, temp, pressures; tuser: rtd_ready
//   rsp     | out       | tvalid / tready   | tdata: temps, pressures; tuser: flags
//   csr     | in        | valid / ready     | index, data
//
// One beat is accepted per cycle unless a stalled output has filled the pipeline; a result
// passes through the median selection and the two constant multiplies of each pressure lane,
// each followed by a register, and then through the output register.
// Reset is synchronous; it empties the pipeline and clears the windows' fill counts.
// A stalled output lets the pipeline keep filling until every stage holds a beat.
// The csr port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sensor_sample_conditioner #(
   parameter int WINDOW_DEPTH = ssc_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // adc_raw[23:0], temp_hundredths[39:24], left_pressure_pa[55:40], right_pressure_pa[71:56]
   input  wire logic [ssc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rtd_ready[0]
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // temp_left[15:0], temp_right[31:16], press_left_mmhg[50:32],
   // press_right_mmhg[69:51], zero[71:70]
   output logic      [ssc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rtd_rejected[0], adc_channel_select[1]
   output logic      [ssc_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ssc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ssc_pkg::CSR_DATA_W-1:0]    csr_data
);

   ssc_pkg::pipe_ctrl_type ctrl;
   ssc_pkg::rtd_result_type rtd_result;
   ssc_pkg::rtd_result_type rtd1_ff, rtd2_ff, rtd3_ff;
   logic vld1_ff, vld2_ff, vld3_ff;
   logic rdy1, rdy2, rdy3;
   logic out_ready;
   logic [ssc_pkg::PRESS_OUT_W-1:0] press_left, press_right;

   assign rdy3 = !vld3_ff || out_ready;
   assign rdy2 = !vld2_ff || rdy3;
   assign rdy1 = !vld1_ff || rdy2;

   assign req_tready = rdy1;
   assign csr_ready  = 1'b1;

   assign ctrl = '{accept: req_tvalid && rdy1, en1: rdy1, en2: rdy2, en3: rdy3};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            vld1_ff <= req_tvalid;
         end
         if (rdy2) begin
            vld2_ff <= vld1_ff;
         end
         if (rdy3) begin
            vld3_ff <= vld2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         rtd1_ff <= rtd_result;
      end
      if (rdy2) begin
         rtd2_ff <= rtd1_ff;
      end
      if (rdy3) begin
         rtd3_ff <= rtd2_ff;
      end
   end

   ssc_rtd_check u_rtd_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .accept          (ctrl.accept),
      .rtd_ready       (req_tuser),
      .adc_raw         (req_tdata[23:0]),
      .temp_hundredths (req_tdata[39:24]),
      .result          (rtd_result)
   );

   ssc_press_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (req_tdata[55:40]),
      .press_mmhg (press_left)
   );

   ssc_press_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (req_tdata[71:56]),
      .press_mmhg (press_right)
   );

   ssc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld3_ff),
      .in_rtd      (rtd3_ff),
      .press_left  (press_left),
      .press_right (press_right),
      .out_ready   (out_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- rtl/ssc_rtd_check.sv -----
// RTD sample validation, channel sequencing and held temperatures.
`timescale 1ns / 1ps
`default_nettype none

module ssc_rtd_check (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [ssc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ssc_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              accept,
   input  wire logic                              rtd_ready,
   input  wire logic [ssc_pkg::RAW_W-1:0]         adc_raw,
   input  wire logic [ssc_pkg::TEMP_W-1:0]        temp_hundredths,
   output ssc_pkg::rtd_result_type                result
);

   logic [ssc_pkg::TEMP_W-1:0] invalid_code_ff;
   logic [ssc_pkg::TEMP_W-1:0] upper_limit_ff;
   logic [ssc_pkg::TEMP_W-1:0] held_left_ff, held_left_in;
   logic [ssc_pkg::TEMP_W-1:0] held_right_ff, held_right_in;
   logic                       channel_ff, channel_in;
   logic                       discard_ff, discard_in;
   logic                       rejected;
   logic                       raw_bad;
   logic                       temp_ok;

   assign raw_bad = (adc_raw == ssc_pkg::RAW_ZERO) || (adc_raw == ssc_pkg::RAW_POS_FULL) ||
                    (adc_raw == ssc_pkg::RAW_NEG_FULL);
   assign temp_ok = !raw_bad && (temp_hundredths != invalid_code_ff) &&
                    (temp_hundredths < upper_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_code_ff <= ssc_pkg::INVALID_TEMP_RESET;
         upper_limit_ff  <= ssc_pkg::UPPER_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssc_pkg::CSR_INVALID_TEMP_CODE: invalid_code_ff <= csr_data;
            ssc_pkg::CSR_UPPER_TEMP_LIMIT:  upper_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      channel_in    = channel_ff;
      discard_in    = discard_ff;
      rejected      = 1'b0;
      if (accept && rtd_ready) begin
         if (discard_ff) begin
            discard_in = 1'b0;
         end else begin
            if (temp_ok) begin
               if (channel_ff) begin
                  held_left_in = temp_hundredths;
               end else begin
                  held_right_in = temp_hundredths;
               end
            end else begin
               rejected = 1'b1;
            end
            channel_in = ~channel_ff;
            discard_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff  <= '0;
         held_right_ff <= '0;
         channel_ff    <= 1'b1;
         discard_ff    <= 1'b0;
      end else begin
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
         channel_ff    <= channel_in;
         discard_ff    <= discard_in;
      end
   end

   assign result = '{temp_left:  held_left_in,
                     temp_right: held_right_in,
                     rejected:   rejected,
                     channel:    channel_in};

endmodule

`default_nettype wire

// ----- rtl/ssc_press_lane.sv -----
// One pressure lane: sample window, median selection and scaling to mmHg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_press_lane #(
   parameter int WINDOW_DEPTH = ssc_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ssc_pkg::pipe_ctrl_type            ctrl,
   input  wire logic [ssc_pkg::SAMPLE_W-1:0]      sample,
   output logic      [ssc_pkg::PRESS_OUT_W-1:0]   press_mmhg
);

   localparam int FW = $clog2(WINDOW_DEPTH + 1);
   localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_DEPTH);
   localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_DEPTH - 1);

   logic [ssc_pkg::SAMPLE_W-1:0] win_ff [WINDOW_DEPTH];
   logic [ssc_pkg::SAMPLE_W-1:0] win_in [WINDOW_DEPTH];
   logic [PW-1:0]                pos_ff, pos_in;
   logic [FW-1:0]                fill_ff, fill_in;
   logic [FW-1:0]                rank [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]      used;
   logic [FW-1:0]                lo_rank, hi_rank;
   logic [ssc_pkg::SAMPLE_W-1:0] sel_lo, sel_hi;

   logic [ssc_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [ssc_pkg::SCALED_W-1:0]  scaled_ff, scaled_in;
   logic [ssc_pkg::QUOT_IN_W-1:0] dividend_ff, dividend_in;
   logic [ssc_pkg::PROD_W-1:0]    recip_prod;
   logic [ssc_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [ssc_pkg::REM_W-1:0]     remainder;
   logic [ssc_pkg::QUOT_W-1:0]    quot_fixed;

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_in[i] = (PW'(i) == pos_ff) ? sample : win_ff[i];
      end
      pos_in  = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      fill_in = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + 1'b1;
   end

   // Each valid entry counts the entries ordered before it; ties break by position.
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         used[i] = FW'(i) < fill_in;
      end
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if (used[j] && (j != i) &&
                ((win_in[j] < win_in[i]) || ((win_in[j] == win_in[i]) && (j < i)))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      lo_rank = (fill_in - 1'b1) >> 1;
      hi_rank = fill_in >> 1;
      sel_lo  = '0;
      sel_hi  = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (used[i] && (rank[i] == lo_rank)) begin
            sel_lo = sel_lo | win_in[i];
         end
         if (used[i] && (rank[i] == hi_rank)) begin
            sel_hi = sel_hi | win_in[i];
         end
      end
      sum_in = {1'b0, sel_lo} + {1'b0, sel_hi};
   end

   assign scaled_in   = ssc_pkg::SCALED_W'(sum_ff) * ssc_pkg::SCALED_W'(ssc_pkg::SCALE_MUL) +
                        ssc_pkg::ROUND_ADD;
   assign dividend_in = scaled_ff[ssc_pkg::SCALED_W-1:ssc_pkg::DIV_SHIFT];
   assign recip_prod  = ssc_pkg::PROD_W'(dividend_in) * ssc_pkg::PROD_W'(ssc_pkg::RECIP_M);
   assign quot_in     = recip_prod[ssc_pkg::PROD_W-1:ssc_pkg::RECIP_SHIFT];

   // The reciprocal estimate is low by at most one.
   assign remainder  = ssc_pkg::REM_W'(dividend_ff) -
                       ssc_pkg::REM_W'(quot_ff) * ssc_pkg::REM_W'(ssc_pkg::DIV_REM);
   assign quot_fixed = (remainder >= ssc_pkg::REM_W'(ssc_pkg::DIV_REM)) ?
                       quot_ff + 1'b1 : quot_ff;
   assign press_mmhg = quot_fixed[ssc_pkg::PRESS_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
      end else if (ctrl.accept) begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         win_ff <= win_in;
      end
      if (ctrl.en1) begin
         sum_ff <= sum_in;
      end
      if (ctrl.en2) begin
         scaled_ff <= scaled_in;
      end
      if (ctrl.en3) begin
         dividend_ff <= dividend_in;
         quot_ff     <= quot_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ssc_merge.sv -----
// Output stage that joins both pressure lanes with the RTD result into one beat.
`timescale 1ns / 1ps
`default_nettype none

module ssc_merge (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire ssc_pkg::rtd_result_type           in_rtd,
   input  wire logic [ssc_pkg::PRESS_OUT_W-1:0]   press_left,
   input  wire logic [ssc_pkg::PRESS_OUT_W-1:0]   press_right,
   output logic                                   out_ready,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [ssc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic      [ssc_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   localparam int PAD_W = ssc_pkg::RSP_TDATA_W - 2 * ssc_pkg::TEMP_W -
                          2 * ssc_pkg::PRESS_OUT_W;

   logic                            valid_ff;
   logic [ssc_pkg::RSP_TDATA_W-1:0] data_ff, data_in;
   logic [ssc_pkg::RSP_TUSER_W-1:0] user_ff, user_in;

   assign out_ready = !valid_ff || rsp_tready;
   assign data_in   = {{PAD_W{1'b0}}, press_right, press_left,
                       in_rtd.temp_right, in_rtd.temp_left};
   assign user_in   = {in_rtd.channel, in_rtd.rejected};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         data_ff <= data_in;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

// ----- rtl/ssc_checker.sv -----
// Port-level checker for the sensor sample conditioner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_sample_conditioner_defines.svh"

module ssc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [ssc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic [ssc_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // A free or draining output stage means every stage behind it can move.
   `SSC_ASSERT_IMPLY(a_ready_when_out_free, !rsp_tvalid || rsp_tready, req_tready)

   // Reset leaves the pipeline empty and ready for a request beat.
   `SSC_ASSERT_NEXT_ANY(a_reset_empties, reset, !rsp_tvalid && req_tready)

   `SSC_ASSERT_NEXT(a_rsp_valid_holds, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `SSC_ASSERT_NEXT(a_rsp_data_holds, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind sensor_sample_conditioner ssc_checker u_checker (.*);

`default_nettype wire

// ----- sim/conditioner_result_checker.sv -----
// Checker that predicts each result beat of the sensor sample conditioner and compares it.
`timescale 1ns / 1ps

module conditioner_result_checker
   import ssc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     pending,
   output int                     checked
);

   localparam int LANES = 2;
   localparam int DEPTH = WINDOW_DEPTH_DEF;
   localparam logic [63:0] MMHG_PER_PA_X2E5 = 64'd750062;
   localparam logic [63:0] HALF_PAIR_DEN    = 64'd100000;
   localparam logic [63:0] PAIR_DEN         = 64'd200000;

   typedef struct packed {
      logic [TEMP_W-1:0]      temp_left;
      logic [TEMP_W-1:0]      temp_right;
      logic                   rejected;
      logic                   channel;
      logic [PRESS_OUT_W-1:0] press_left;
      logic [PRESS_OUT_W-1:0] press_right;
   } conditioned_beat_type;

   logic [TEMP_W-1:0]    invalid_code;
   logic [TEMP_W-1:0]    upper_limit;
   logic [SAMPLE_W-1:0]  press_win [LANES][DEPTH];
   int                   press_pos [LANES];
   int                   press_fill [LANES];
   logic [TEMP_W-1:0]    held_left;
   logic [TEMP_W-1:0]    held_right;
   logic                 channel;
   logic                 discard_next;
   conditioned_beat_type expected_beats [$];
   int                   fail_count = 0;
   int                   beat_count = 0;

   // The window value is formed as twice the median, or during warm-up as twice the first
   // sample or the sum of the two samples, so one rounded division covers every case.
   function automatic logic [PRESS_OUT_W-1:0] filter_pressure(input int lane,
                                                              input logic [SAMPLE_W-1:0] sample);
      logic [SAMPLE_W-1:0] a;
      logic [SAMPLE_W-1:0] b;
      logic [SAMPLE_W-1:0] c;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      logic [SAMPLE_W-1:0] mid;
      logic [SUM_W-1:0]    pair_sum;
      logic [63:0]         scaled;
      press_win[lane][press_pos[lane]] = sample;
      press_pos[lane] = (press_pos[lane] + 1) % DEPTH;
      if (press_fill[lane] < DEPTH) press_fill[lane]++;
      a = press_win[lane][0];
      b = press_win[lane][1];
      c = press_win[lane][2];
      case (press_fill[lane])
         1: pair_sum = {a, 1'b0};
         2: pair_sum = {1'b0, a} + {1'b0, b};
         default: begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            mid = (hi < c) ? hi : c;
            mid = (lo > mid) ? lo : mid;
            pair_sum = {mid, 1'b0};
         end
      endcase
      scaled = (64'(pair_sum) * MMHG_PER_PA_X2E5 + HALF_PAIR_DEN) / PAIR_DEN;
      return scaled[PRESS_OUT_W-1:0];
   endfunction

   function automatic conditioned_beat_type condition_sample(input logic rtd_ready,
                                                             input logic [RAW_W-1:0] raw,
                                                             input logic [TEMP_W-1:0] temp,
                                                             input logic [SAMPLE_W-1:0] left_pa,
                                                             input logic [SAMPLE_W-1:0] right_pa);
      conditioned_beat_type beat;
      logic                 good;
      beat.rejected = 1'b0;
      if (rtd_ready) begin
         if (discard_next) begin
            discard_next = 1'b0;
         end else begin
            good = (raw != RAW_ZERO) && (raw != RAW_POS_FULL) && (raw != RAW_NEG_FULL) &&
                   (temp != invalid_code) && (temp < upper_limit);
            if (!good) begin
               beat.rejected = 1'b1;
            end else if (channel) begin
               held_left = temp;
            end else begin
               held_right = temp;
            end
            channel = ~channel;
            discard_next = 1'b1;
         end
      end
      beat.press_left = filter_pressure(0, left_pa);
      beat.press_right = filter_pressure(1, right_pa);
      beat.temp_left = held_left;
      beat.temp_right = held_right;
      beat.channel = channel;
      return beat;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      conditioned_beat_type want;
      if (reset) begin
         invalid_code = INVALID_TEMP_RESET;
         upper_limit = UPPER_LIMIT_RESET;
         press_pos = '{0, 0};
         press_fill = '{0, 0};
         held_left = '0;
         held_right = '0;
         channel = 1'b1;
         discard_next = 1'b0;
         expected_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INVALID_TEMP_CODE: invalid_code = csr_data;
               CSR_UPPER_TEMP_LIMIT: upper_limit = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_beats.push_back(condition_sample(req_tuser, req_tdata[23:0],
                                                      req_tdata[39:24], req_tdata[55:40],
                                                      req_tdata[71:56]));
         end
         if (rsp_tvalid && rsp_tready) begin
            beat_count++;
            if (expected_beats.size() == 0) begin
               $error("Result beat arrived with no request beat waiting for it.");
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("temp_left", 32'(want.temp_left), 32'(rsp_tdata[15:0]));
               check_field("temp_right", 32'(want.temp_right), 32'(rsp_tdata[31:16]));
               check_field("press_left_mmhg", 32'(want.press_left), 32'(rsp_tdata[50:32]));
               check_field("press_right_mmhg", 32'(want.press_right), 32'(rsp_tdata[69:51]));
               check_field("tdata padding", 32'd0, 32'(rsp_tdata[71:70]));
               check_field("rtd_rejected", 32'(want.rejected), 32'(rsp_tuser[0]));
               check_field("adc_channel_select", 32'(want.channel), 32'(rsp_tuser[1]));
            end
         end
      end
      mismatches <= fail_count;
      pending <= expected_beats.size();
      checked <= beat_count;
   end

endmodule

// ----- sim/sensor_sample_conditioner_test.sv -----
// Testbench top that drives the sensor sample conditioner and reports the verdict.
`timescale 1ns / 1ps

module sensor_sample_conditioner_test;
   import ssc_pkg::*;

   localparam int CLOCK_PERIOD           = 10;
   localparam int RESET_CYCLES           = 12;
   localparam int LONG_HOLD_CYCLES       = 150;
   localparam int DRAIN_LIMIT            = 5000;
   localparam int SETTLE_CYCLES          = 8;
   localparam int RANDOM_PHASES          = 6;
   localparam int RANDOM_ITEMS_PER_PHASE = 170;
   localparam int TIMEOUT_NS             = 2_000_000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX  = 4'd15;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatches;
   int pending;
   int checked;

   logic              req_idle_on = 1'b1;
   logic              rsp_idle_on = 1'b1;
   logic              long_hold_req = 1'b0;
   logic [TEMP_W-1:0] cur_invalid = INVALID_TEMP_RESET;
   logic [TEMP_W-1:0] cur_limit = UPPER_LIMIT_RESET;
   int                items_sent = 0;
   int                settings_used = 1;

   sensor_sample_conditioner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   conditioner_result_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic send_item(input logic rtd_ready, input logic [RAW_W-1:0] raw,
                            input logic [TEMP_W-1:0] temp, input logic [SAMPLE_W-1:0] left_pa,
                            input logic [SAMPLE_W-1:0] right_pa);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rtd_ready;
      req_tdata <= {right_pa, left_pa, temp, raw};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_pressure();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SAMPLE_W'(25000);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_item();
      logic [RAW_W-1:0]  raw;
      logic [TEMP_W-1:0] temp;
      case ($urandom_range(0, 11))
         0: raw = RAW_ZERO;
         1: raw = RAW_POS_FULL;
         2: raw = RAW_NEG_FULL;
         default: raw = RAW_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: temp = cur_invalid;
         1: temp = cur_limit;
         2: temp = TEMP_W'($urandom_range(65535, int'(cur_limit)));
         3: temp = TEMP_W'($urandom);
         default: begin
            if (cur_limit == 0) temp = TEMP_W'($urandom);
            else temp = TEMP_W'($urandom_range(int'(cur_limit) - 1, 0));
         end
      endcase
      send_item($urandom_range(0, 9) < 6, raw, temp, pick_pressure(), pick_pressure());
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [TEMP_W-1:0] invalid_code,
                            input logic [TEMP_W-1:0] limit);
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      write_csr(CSR_INVALID_TEMP_CODE, invalid_code);
      write_csr(CSR_UPPER_TEMP_LIMIT, limit);
      write_csr(CSR_LAST_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      cur_invalid = invalid_code;
      cur_limit = limit;
      settings_used++;
   endtask

   task automatic wait_idle();
      int waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Warm-up of both windows with halfway rounding, then every reason to reject a reading.
      send_item(1'b0, 24'h123456, 16'd2500, 16'd20000, 16'hFFFF);
      send_item(1'b1, 24'h123456, 16'd2500, 16'd30000, 16'h0000);
      send_item(1'b1, 24'h000001, 16'd100, 16'd25000, 16'd25000);
      send_item(1'b1, RAW_ZERO, 16'd1000, 16'h0000, 16'hFFFF);
      send_item(1'b1, 24'h000001, 16'd1000, 16'hFFFF, 16'h0000);
      send_item(1'b1, RAW_POS_FULL, 16'd1000, 16'hAAAA, 16'h5555);
      send_item(1'b1, 24'hAAAAAA, 16'd1000, 16'h5555, 16'hAAAA);
      send_item(1'b1, RAW_NEG_FULL, 16'd1000, 16'hFFFF, 16'hFFFF);
      send_item(1'b1, 24'h555555, 16'd1000, 16'h0001, 16'h8000);
      send_item(1'b1, 24'h800000, 16'hFFFF, 16'h8000, 16'h0001);
      send_item(1'b1, 24'h000001, 16'd1000, 16'h7FFF, 16'h7FFF);
      send_item(1'b1, 24'h7FFFFE, 16'd8000, 16'd25000, 16'd25000);
      send_item(1'b1, 24'h000001, 16'd1000, 16'h0000, 16'h0000);
      send_item(1'b1, 24'hFFFFFE, 16'd7999, 16'h1234, 16'hFEDC);
      send_item(1'b0, RAW_ZERO, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_item(1'b1, 24'h800001, 16'd4000, 16'h0000, 16'hFFFF);
      send_item(1'b1, 24'h000001, 16'd0, 16'hFFFF, 16'hFFFF);

      wait_idle();
      configure(16'd1234, 16'hFFFF);
      send_item(1'b1, 24'h345678, 16'd500, 16'h4321, 16'h8765);
      send_item(1'b1, 24'h345678, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_item(1'b1, 24'h345678, 16'd500, 16'hFFFF, 16'h0000);
      send_item(1'b1, 24'h345678, 16'd1234, 16'd25000, 16'd25000);
      send_item(1'b1, 24'h345678, 16'd500, 16'h00FF, 16'hFF00);
      send_item(1'b1, 24'h345678, 16'hFFFE, 16'hFF00, 16'h00FF);

      wait_idle();
      configure(16'h0000, 16'h0000);
      send_item(1'b1, 24'h654321, 16'd0, 16'h0F0F, 16'hF0F0);
      send_item(1'b1, 24'h654321, 16'd0, 16'hF0F0, 16'h0F0F);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: configure(TEMP_W'($urandom), TEMP_W'($urandom_range(12000, 4000)));
            1: configure('0, '1);
            2: configure('1, '0);
            3: configure(TEMP_W'($urandom_range(7999, 0)), UPPER_LIMIT_RESET);
            4: configure(TEMP_W'($urandom), TEMP_W'($urandom));
            default: configure(INVALID_TEMP_RESET, UPPER_LIMIT_RESET);
         endcase
         req_idle_on = (phase != 3) && (phase != RANDOM_PHASES - 1);
         rsp_idle_on = (phase != RANDOM_PHASES - 1);
         if (phase == 1) long_hold_req = 1'b1;
         repeat (RANDOM_ITEMS_PER_PHASE) send_random_item();
      end
      wait_idle();

      if (pending != 0) $error("%0d expected result beats never arrived.", pending);
      $display("Summary: %0d request beats under %0d register settings, %0d result beats checked.",
               items_sent, settings_used, checked);
      $display("Summary: the output was held off once for %0d cycles while requests kept coming.",
               LONG_HOLD_CYCLES);
      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
